// File: hw/rtl/grid_local_minimum_risk_sum_core_assert.svh
// Assertion macros shared by the core, glmrs_seq and glmrs_eval.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_CORE_ASSERT_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define GLMRS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define GLMRS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/glmrs_pkg.sv
package glmrs_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam int DIM_W       = 8;
    localparam int HEIGHT_W    = 4;
    localparam int SUM_W       = 18;
    localparam int ADD_W       = 6;
    localparam int WORD_W      = 2 * HEIGHT_W;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DIM_W-1:0]    DIM_RESET = 8'd100;
    localparam logic [HEIGHT_W-1:0] LOW_LIMIT = 4'd9;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Position of one request within the grid, decided when it is accepted.
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic last_row;
        logic c_ge1;
        logic c_ge2;
        logic end_col;
        logic grid_end;
    } cell_flags_t;

    // Returns height plus one for a low point and zero otherwise.
    function automatic logic [HEIGHT_W-1:0] judge(
        input logic                s,
        input logic                hl,
        input logic [HEIGHT_W-1:0] l,
        input logic                hr,
        input logic [HEIGHT_W-1:0] r,
        input logic                hu,
        input logic [HEIGHT_W-1:0] u,
        input logic                hd,
        input logic [HEIGHT_W-1:0] d,
        input logic [HEIGHT_W-1:0] sv
    );
        logic ok;
        ok = s && (sv < LOW_LIMIT)
            && (!hl || (sv < l)) && (!hr || (sv < r))
            && (!hu || (sv < u)) && (!hd || (sv < d));
        return ok ? sv + 4'd1 : '0;
    endfunction

endpackage

// File: hw/rtl/grid_local_minimum_risk_sum_core.sv
// The risk sum is registered: the last cell of a grid passes the evaluation stage, then the output register.
// Throughput: one cell per cycle unless stalled, set by the single read and single write
// per cycle of the row store RAM; a same-column read and write is covered by forwarding.
// Input stalls only while a finished sum waits and the next grid ends as well.
// Reset clears counters, the running sum and valid flags and sets both dimensions
// to 100; the row store is not cleared, as words read in a grid's first row are unused.
`include "grid_local_minimum_risk_sum_core_assert.svh"

module grid_local_minimum_risk_sum_core #(
    parameter int MAX_WIDTH  = glmrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = glmrs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [glmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [glmrs_pkg::DIM_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [glmrs_pkg::HEIGHT_W-1:0]       height,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [glmrs_pkg::SUM_W-1:0]          risk_sum
);

    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                          acc;
    logic                          advance;
    logic [CAW-1:0]                cell_addr;
    glmrs_pkg::cell_flags_t        cell_flags;
    logic [glmrs_pkg::WORD_W-1:0]  rd_data;
    logic                          wr_en;
    logic [CAW-1:0]                wr_addr;
    logic [glmrs_pkg::WORD_W-1:0]  wr_data;
    logic                          pend_end;
    logic                          final_done;
    logic [glmrs_pkg::SUM_W-1:0]   final_sum;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [glmrs_pkg::SUM_W-1:0]   risk_sum_reg;

    assign advance  = !(pend_end && out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign acc      = in_valid && advance;

    glmrs_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .acc        (acc),
        .cell_addr  (cell_addr),
        .cell_flags (cell_flags)
    );

    glmrs_ram #(
        .WIDTH (glmrs_pkg::WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (acc),
        .rd_addr (cell_addr),
        .rd_data (rd_data)
    );

    glmrs_eval #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_clear  (cfg_write),
        .advance    (advance),
        .acc        (acc),
        .in_height  (height),
        .in_addr    (cell_addr),
        .in_flags   (cell_flags),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .pend_end   (pend_end),
        .final_done (final_done),
        .final_sum  (final_sum)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (final_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (final_done)
        begin
            risk_sum_reg <= final_sum;
        end
    end

    assign out_valid = out_valid_reg;
    assign risk_sum  = risk_sum_reg;

    `GLMRS_ASSERT_SAME(a_stall_cause, in_stall, out_valid_reg && out_stall,
        "Input stalled while the output register was free.")
    `GLMRS_ASSERT_NEXT(a_final_shown, final_done, out_valid_reg,
        "Finished sum was not presented.")
    `GLMRS_ASSERT_NEXT(a_final_value, final_done, risk_sum_reg == $past(final_sum),
        "Presented sum differs from the finished sum.")

endmodule

// File: hw/rtl/glmrs_ram.sv
module glmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/glmrs_seq.sv
`include "grid_local_minimum_risk_sum_core_assert.svh"

module glmrs_seq #(
    parameter int MAX_WIDTH  = glmrs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = glmrs_pkg::MAX_HEIGHT_DEF,
    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [glmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [glmrs_pkg::DIM_W-1:0]          cfg_data,
    input  logic                                 acc,
    output logic [CAW-1:0]                       cell_addr,
    output glmrs_pkg::cell_flags_t               cell_flags
);

    logic [glmrs_pkg::DIM_W-1:0] width_reg;
    logic [glmrs_pkg::DIM_W-1:0] height_reg;
    logic [CAW-1:0]              col_reg;
    logic [CAW-1:0]              col_next;
    logic [RAW-1:0]              row_reg;
    logic [RAW-1:0]              row_next;
    logic [CAW-1:0]              last_col;
    logic [RAW-1:0]              last_row_v;
    logic                        end_col;
    logic                        row_last;

    // A dimension of zero acts as one, and one above the maximum saturates.
    always_comb
    begin
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = CAW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = CAW'(width_reg - 8'd1);
        end

        if (height_reg == '0)
        begin
            last_row_v = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            last_row_v = RAW'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_row_v = RAW'(height_reg - 8'd1);
        end
    end

    assign end_col  = (col_reg == last_col);
    assign row_last = (row_reg == last_row_v);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RAW'(1);
            end
            else
            begin
                col_next = col_reg + CAW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= glmrs_pkg::DIM_RESET;
            height_reg <= glmrs_pkg::DIM_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                glmrs_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                glmrs_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign cell_addr           = col_reg;
    assign cell_flags.r_ge1    = (row_reg != '0);
    assign cell_flags.r_ge2    = (row_reg > RAW'(1));
    assign cell_flags.last_row = row_last;
    assign cell_flags.c_ge1    = (col_reg != '0);
    assign cell_flags.c_ge2    = (col_reg > CAW'(1));
    assign cell_flags.end_col  = end_col;
    assign cell_flags.grid_end = end_col && row_last;

    `GLMRS_ASSERT_NEXT(a_col_wrap, acc && !cfg_write && end_col, col_reg == '0,
        "Column counter did not wrap at the end of a row.")

endmodule

// File: hw/rtl/glmrs_eval.sv
`include "grid_local_minimum_risk_sum_core_assert.svh"

module glmrs_eval #(
    parameter int MAX_WIDTH = glmrs_pkg::MAX_WIDTH_DEF,
    localparam int CAW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_clear,
    input  logic                                 advance,
    input  logic                                 acc,
    input  logic [glmrs_pkg::HEIGHT_W-1:0]       in_height,
    input  logic [CAW-1:0]                       in_addr,
    input  glmrs_pkg::cell_flags_t               in_flags,
    input  logic [glmrs_pkg::WORD_W-1:0]         rd_data,
    output logic                                 wr_en,
    output logic [CAW-1:0]                       wr_addr,
    output logic [glmrs_pkg::WORD_W-1:0]         wr_data,
    output logic                                 pend_end,
    output logic                                 final_done,
    output logic [glmrs_pkg::SUM_W-1:0]          final_sum
);

    localparam int HW = glmrs_pkg::HEIGHT_W;
    localparam int SW = glmrs_pkg::SUM_W;
    localparam int AW = glmrs_pkg::ADD_W;

    logic                          b_valid_reg;
    glmrs_pkg::cell_flags_t        b_flags_reg;
    logic [CAW-1:0]                b_addr_reg;
    logic [HW-1:0]                 b_height_reg;
    logic                          fwd_hit_reg;
    logic [glmrs_pkg::WORD_W-1:0]  fwd_data_reg;
    logic [HW-1:0]                 c1_u_reg;
    logic [HW-1:0]                 c1_m_reg;
    logic [HW-1:0]                 c1_d_reg;
    logic [HW-1:0]                 c2_m_reg;
    logic [HW-1:0]                 c2_d_reg;
    logic [SW-1:0]                 total_reg;
    logic [SW-1:0]                 total_next;

    logic [glmrs_pkg::WORD_W-1:0]  cur_word;
    logic [HW-1:0]                 cur_u;
    logic [HW-1:0]                 cur_m;
    logic [HW-1:0]                 cur_d;
    logic [HW-1:0]                 j_mid_left;
    logic [HW-1:0]                 j_low_left;
    logic [HW-1:0]                 j_mid_end;
    logic [HW-1:0]                 j_low_end;
    logic [AW-1:0]                 add;
    logic                          step;

    // The row store word holds the row two above in its upper half and the
    // row just above in its lower half.
    assign cur_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign cur_u    = cur_word[glmrs_pkg::WORD_W-1:HW];
    assign cur_m    = cur_word[HW-1:0];
    assign cur_d    = b_height_reg;

    // The cells of the previous column are judged now that their right
    // neighbors are here; at the end of a row the current column is judged too.
    always_comb
    begin
        j_mid_left = glmrs_pkg::judge(b_flags_reg.r_ge1 && b_flags_reg.c_ge1,
            b_flags_reg.c_ge2, c2_m_reg, 1'b1, cur_m,
            b_flags_reg.r_ge2, c1_u_reg, 1'b1, c1_d_reg, c1_m_reg);
        j_low_left = glmrs_pkg::judge(b_flags_reg.last_row && b_flags_reg.c_ge1,
            b_flags_reg.c_ge2, c2_d_reg, 1'b1, cur_d,
            b_flags_reg.r_ge1, c1_m_reg, 1'b0, '0, c1_d_reg);
        j_mid_end = glmrs_pkg::judge(b_flags_reg.r_ge1 && b_flags_reg.end_col,
            b_flags_reg.c_ge1, c1_m_reg, 1'b0, '0,
            b_flags_reg.r_ge2, cur_u, 1'b1, cur_d, cur_m);
        j_low_end = glmrs_pkg::judge(b_flags_reg.last_row && b_flags_reg.end_col,
            b_flags_reg.c_ge1, c1_d_reg, 1'b0, '0,
            b_flags_reg.r_ge1, cur_m, 1'b0, '0, cur_d);
        add = AW'(j_mid_left) + AW'(j_low_left) + AW'(j_mid_end) + AW'(j_low_end);
    end

    assign step       = b_valid_reg && advance;
    assign wr_en      = step;
    assign wr_addr    = b_addr_reg;
    assign wr_data    = {cur_m, cur_d};
    assign pend_end   = b_valid_reg && b_flags_reg.grid_end;
    assign final_done = step && b_flags_reg.grid_end;
    assign final_sum  = total_reg + SW'(add);

    always_comb
    begin
        total_next = total_reg;
        if (cfg_clear)
        begin
            total_next = '0;
        end
        else if (step)
        begin
            total_next = b_flags_reg.grid_end ? '0 : final_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            total_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            if (advance)
            begin
                b_valid_reg <= acc;
            end
            if (acc)
            begin
                fwd_hit_reg <= b_valid_reg && (b_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_flags_reg  <= in_flags;
            b_addr_reg   <= in_addr;
            b_height_reg <= in_height;
            fwd_data_reg <= wr_data;
        end
        if (step)
        begin
            c1_u_reg <= cur_u;
            c1_m_reg <= cur_m;
            c1_d_reg <= cur_d;
            c2_m_reg <= c1_m_reg;
            c2_d_reg <= c1_d_reg;
        end
    end

    `GLMRS_ASSERT_SAME(a_end_position, pend_end,
        b_flags_reg.end_col && b_flags_reg.last_row,
        "Grid end flagged away from the last cell.")

endmodule
